@@ hw/rtl/pcl_pkg.sv @@
// Shared constants, command codes and control/status types for the
// page cache LRU controller. No dependencies.
`default_nettype none
package pcl_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int SLOT_OUT_W = 4;
  localparam int PAGE_W     = 16;
  localparam int AGE_W      = 32;
  localparam int CMD_W      = 2;

  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SYNC  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic scan_step;
    logic idx_inc;
    logic decide;
    logic load_wb;
    logic load_close;
    logic load_unknown;
  } pcl_cmd_t;

  // Status from the datapath back to the controller
  typedef struct packed {
    logic idx_last;
    logic sync_hit;
  } pcl_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/page_cache_lru_controller.sv @@
// Page cache LRU controller: request (command, page, fill_error) channel in,
// result channel out, both valid/ready; one beat moves on valid && ready.
// A read or write access gives one result beat (last=1): hit with slot, or
// miss with the victim slot, fill_needed and any dirty writeback (slot 0,
// ok=0 on a read fill_error). Sync gives one beat per dirty valid slot in
// slot order (last=0), then a closing beat with last=1. An unknown command
// gives one beat with ok=0. Timing: one item at a time. An access scans
// the slots one per cycle, doing lookup and victim choice together through
// one slot read port, then applies its update in the DECIDE state and
// loads the result register. Sync walks the slots one per cycle between
// beats; each dirty slot reported adds the beat itself and a second look at
// the same slot; an unknown command answers in the cycle after acceptance.
// The next request is taken only after the last result beat is accepted;
// a stalled receiver holds the result register and the scan position.
// Reset (rst, synchronous) empties every slot and clears all ages and the
// age counter; the block is ready on the first cycle after reset.
// Depends on pcl_pkg, pcl_ctrl and pcl_datapath.
`default_nettype none
module page_cache_lru_controller (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [pcl_pkg::CMD_W-1:0]     command,
  input  wire logic [pcl_pkg::PAGE_W-1:0]    page,
  input  wire logic                          fill_error,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               hit,
  output logic                               ok,
  output logic [pcl_pkg::SLOT_OUT_W-1:0]     slot,
  output logic                               fill_needed,
  output logic                               zero_filled,
  output logic                               writeback_valid,
  output logic [pcl_pkg::PAGE_W-1:0]         writeback_page,
  output logic                               last
);
  import pcl_pkg::*;

  pcl_cmd_t  cmd;
  pcl_stat_t stat;

  pcl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  pcl_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .command         (command),
    .page            (page),
    .fill_error      (fill_error),
    .hit             (hit),
    .ok              (ok),
    .slot            (slot),
    .fill_needed     (fill_needed),
    .zero_filled     (zero_filled),
    .writeback_valid (writeback_valid),
    .writeback_page  (writeback_page),
    .last            (last)
  );

endmodule
`default_nettype wire

@@ hw/rtl/pcl_datapath.sv @@
// Slot state (tags, valid, dirty, ages), scan registers and result register.
// Depends on pcl_pkg; driven by pcl_ctrl commands.
`default_nettype none
module pcl_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire pcl_pkg::pcl_cmd_t             cmd,
  output pcl_pkg::pcl_stat_t                 stat,
  input  wire logic [pcl_pkg::CMD_W-1:0]     command,
  input  wire logic [pcl_pkg::PAGE_W-1:0]    page,
  input  wire logic                          fill_error,
  output logic                               hit,
  output logic                               ok,
  output logic [pcl_pkg::SLOT_OUT_W-1:0]     slot,
  output logic                               fill_needed,
  output logic                               zero_filled,
  output logic                               writeback_valid,
  output logic [pcl_pkg::PAGE_W-1:0]         writeback_page,
  output logic                               last
);
  import pcl_pkg::*;

  logic [PAGE_W-1:0] slot_tag   [SLOTS];
  logic              slot_valid [SLOTS];
  logic              slot_dirty [SLOTS];
  logic [AGE_W-1:0]  slot_age   [SLOTS];
  logic [AGE_W-1:0]  age_counter;

  logic [CMD_W-1:0]  cmd_q;
  logic [PAGE_W-1:0] page_q;
  logic              ferr_q;
  logic [SLOT_W-1:0] idx;
  logic              hit_found;
  logic [SLOT_W-1:0] hit_idx;
  logic [SLOT_W-1:0] vict;
  logic              vict_done;
  logic [AGE_W-1:0]  best_age;

  logic [AGE_W-1:0]  age_inc;
  logic              vict_wb;

  assign age_inc       = age_counter + AGE_W'(1);
  assign vict_wb       = slot_valid[vict] && slot_dirty[vict];
  assign stat.idx_last = (idx == SLOT_W'(SLOTS - 1));
  assign stat.sync_hit = slot_valid[idx] && slot_dirty[idx];

  // Slot state and control-related registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_valid[i] <= 1'b0;
        slot_dirty[i] <= 1'b0;
        slot_age[i]   <= '0;
      end
      age_counter <= '0;
      idx         <= '0;
    end else begin
      if (cmd.capture) idx <= '0;
      else if (cmd.idx_inc) idx <= idx + SLOT_W'(1);

      // Apply an access once the scan has finished
      if (cmd.decide) begin
        if (hit_found) begin
          slot_age[hit_idx] <= age_inc;
          age_counter       <= age_inc;
          if (cmd_q == CMD_WRITE) slot_dirty[hit_idx] <= 1'b1;
        end else if (ferr_q && cmd_q == CMD_READ) begin
          slot_valid[vict] <= 1'b0;
          slot_dirty[vict] <= 1'b0;
        end else begin
          slot_valid[vict] <= 1'b1;
          slot_dirty[vict] <= (cmd_q == CMD_WRITE);
          slot_age[vict]   <= age_inc;
          age_counter      <= age_inc;
        end
      end

      // Sync cleans the slot it reports
      if (cmd.load_wb) slot_dirty[idx] <= 1'b0;
    end
  end

  // Tags, captured request and scan tracking
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q     <= command;
      page_q    <= page;
      ferr_q    <= fill_error;
      hit_found <= 1'b0;
      hit_idx   <= '0;
      vict      <= '0;
      vict_done <= 1'b0;
    end
    if (cmd.scan_step) begin
      if (slot_valid[idx] && slot_tag[idx] == page_q) begin
        hit_found <= 1'b1;
        hit_idx   <= idx;
      end
      if (idx == '0) begin
        best_age <= slot_age[idx];
      end else if (!vict_done) begin
        if (!slot_valid[idx]) begin
          vict      <= idx;
          vict_done <= 1'b1;
        end else if (slot_age[idx] < best_age) begin
          vict     <= idx;
          best_age <= slot_age[idx];
        end
      end
    end
    if (cmd.decide && !hit_found) slot_tag[vict] <= page_q;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      last <= 1'b1;
      if (hit_found) begin
        hit             <= 1'b1;
        ok              <= 1'b1;
        slot            <= SLOT_OUT_W'(hit_idx);
        fill_needed     <= 1'b0;
        zero_filled     <= 1'b0;
        writeback_valid <= 1'b0;
        writeback_page  <= '0;
      end else begin
        hit             <= 1'b0;
        fill_needed     <= 1'b1;
        writeback_valid <= vict_wb;
        writeback_page  <= vict_wb ? slot_tag[vict] : '0;
        if (ferr_q && cmd_q == CMD_READ) begin
          ok          <= 1'b0;
          slot        <= '0;
          zero_filled <= 1'b0;
        end else begin
          ok          <= 1'b1;
          slot        <= SLOT_OUT_W'(vict);
          zero_filled <= ferr_q;
        end
      end
    end else if (cmd.load_wb) begin
      hit             <= 1'b0;
      ok              <= 1'b1;
      slot            <= SLOT_OUT_W'(idx);
      fill_needed     <= 1'b0;
      zero_filled     <= 1'b0;
      writeback_valid <= 1'b1;
      writeback_page  <= slot_tag[idx];
      last            <= 1'b0;
    end else if (cmd.load_close || cmd.load_unknown) begin
      hit             <= 1'b0;
      ok              <= cmd.load_close;
      slot            <= '0;
      fill_needed     <= 1'b0;
      zero_filled     <= 1'b0;
      writeback_valid <= 1'b0;
      writeback_page  <= '0;
      last            <= 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/pcl_ctrl.sv @@
// Sequencing state machine for the page cache LRU controller.
// Depends on pcl_pkg; drives pcl_datapath through command/status structs.
`default_nettype none
module pcl_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [pcl_pkg::CMD_W-1:0] command,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output pcl_pkg::pcl_cmd_t              cmd,
  input  wire pcl_pkg::pcl_stat_t        stat
);
  import pcl_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN      = 3'd1;
  localparam logic [2:0] S_DECIDE    = 3'd2;
  localparam logic [2:0] S_SYNC      = 3'd3;
  localparam logic [2:0] S_EMIT_MORE = 3'd4;
  localparam logic [2:0] S_EMIT_LAST = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT_MORE) || (state == S_EMIT_LAST);

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (command == CMD_SYNC) begin
            state_next = S_SYNC;
          end else if (command == CMD_READ || command == CMD_WRITE) begin
            state_next = S_SCAN;
          end else begin
            cmd.load_unknown = 1'b1;
            state_next       = S_EMIT_LAST;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.idx_inc   = 1'b1;
        if (stat.idx_last) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_EMIT_LAST;
      end
      S_SYNC: begin
        // dirty bit is cleared on report, so the same slot advances next time
        if (stat.sync_hit) begin
          cmd.load_wb = 1'b1;
          state_next  = S_EMIT_MORE;
        end else if (stat.idx_last) begin
          cmd.load_close = 1'b1;
          state_next     = S_EMIT_LAST;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_EMIT_MORE: begin
        if (out_ready) state_next = S_SYNC;
      end
      S_EMIT_LAST: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule
`default_nettype wire

@@ hw/rtl/pcl_checker.sv @@
// Port-level checks for page_cache_lru_controller, bound to the top level.
// Depends on pcl_pkg widths only.
`default_nettype none
module pcl_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic                      hit,
  input wire logic                      ok,
  input wire logic [pcl_pkg::SLOT_OUT_W-1:0] slot,
  input wire logic                      fill_needed,
  input wire logic                      writeback_valid,
  input wire logic [pcl_pkg::PAGE_W-1:0] writeback_page,
  input wire logic                      last
);
  import pcl_pkg::*;

  // No new request while a result is pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("request taken with result pending");

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(writeback_page) && $stable(last)
      && $stable(slot)) else $error("stalled result changed");

  a_wb_page_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !writeback_valid |-> writeback_page == '0)
    else $error("writeback page without writeback");

  a_hit_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> ok && !fill_needed && !writeback_valid && last)
    else $error("bad hit result");

  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> slot == '0 && !hit && last)
    else $error("bad failure result");

endmodule

bind page_cache_lru_controller pcl_checker u_pcl_checker (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .hit             (hit),
  .ok              (ok),
  .slot            (slot),
  .fill_needed     (fill_needed),
  .writeback_valid (writeback_valid),
  .writeback_page  (writeback_page),
  .last            (last)
);
`default_nettype wire

@@ sim/testbench.sv @@
// Testbench for page_cache_lru_controller: a scoreboard class predicts
// every result beat of the slot tracker, and plain tasks drive the request channel.
// Depends on pcl_pkg and the page_cache_lru_controller RTL.
`timescale 1ns / 100ps
`default_nettype none

typedef struct {
  bit        hit;
  bit        ok;
  bit [3:0]  slot;
  bit        fill_needed;
  bit        zero_filled;
  bit        wb_valid;
  bit [15:0] wb_page;
  bit        last;
} cache_beat_t;

class cache_scoreboard;
  localparam int NSLOT  = pcl_pkg::SLOTS;
  localparam int NPROBE = 64;
  localparam bit [7:0] EMPTY = 8'hFF;

  bit [15:0]   tag [NSLOT];
  bit          valid [NSLOT];
  bit          dirty [NSLOT];
  bit [31:0]   age [NSLOT];
  bit [31:0]   age_count;
  bit [7:0]    probe [NPROBE];
  cache_beat_t pending [$];
  int          errors;
  int          beats_seen;
  int          writebacks_seen;
  int          hits_seen;

  function new();
    for (int i = 0; i < NSLOT; i++) begin
      tag[i] = 0; valid[i] = 0; dirty[i] = 0; age[i] = 0;
    end
    for (int i = 0; i < NPROBE; i++) probe[i] = EMPTY;
    age_count = 0;
    errors = 0;
  endfunction

  function int wrap(int s);
    return (s + 1 >= NPROBE) ? 0 : s + 1;
  endfunction

  function void probe_put(bit [15:0] pg, int idx);
    int s;
    s = pg % NPROBE;
    for (int n = 0; n < NPROBE; n++) begin
      if (probe[s] == EMPTY) begin
        probe[s] = idx[7:0];
        return;
      end
      s = wrap(s);
    end
  endfunction

  // delete the entry and rehash the rest of its cluster
  function void probe_drop(bit [15:0] pg, int idx);
    int s, nx, re;
    s = pg % NPROBE;
    for (int n = 0; n < NPROBE; n++) begin
      if (probe[s] == EMPTY) return;
      if (probe[s] == idx[7:0]) begin
        nx = wrap(s);
        probe[s] = EMPTY;
        for (int k = 0; k < NPROBE && probe[nx] != EMPTY; k++) begin
          re = probe[nx];
          probe[nx] = EMPTY;
          if (re < NSLOT && valid[re]) probe_put(tag[re], re);
          nx = wrap(nx);
        end
        return;
      end
      s = wrap(s);
    end
  endfunction

  function int probe_lookup(bit [15:0] pg);
    int s, e;
    s = pg % NPROBE;
    for (int n = 0; n < NPROBE; n++) begin
      e = probe[s];
      if (e == EMPTY) return -1;
      if (e < NSLOT && valid[e] && tag[e] == pg) return e;
      s = wrap(s);
    end
    return -1;
  endfunction

  function void push(bit h, bit o, int sl, bit fn, bit zf, bit wv, bit [15:0] wp, bit l);
    cache_beat_t b;
    b.hit = h; b.ok = o; b.slot = sl[3:0]; b.fill_needed = fn; b.zero_filled = zf;
    b.wb_valid = wv; b.wb_page = wp; b.last = l;
    pending.push_back(b);
  endfunction

  // accepted request beat: update the cache image and queue its results
  function void note_request(bit [1:0] cmd, bit [15:0] pg, bit ferr);
    int h, v;
    bit wv;
    bit [15:0] wp;
    wv = 0; wp = 0;
    if (cmd == 2'd3) begin
      push(0, 0, 0, 0, 0, 0, 0, 1);
      return;
    end
    if (cmd == pcl_pkg::CMD_SYNC) begin
      for (int i = 0; i < NSLOT; i++)
        if (valid[i] && dirty[i]) begin
          dirty[i] = 0;
          push(0, 1, i, 0, 0, 1, tag[i], 0);
        end
      push(0, 1, 0, 0, 0, 0, 0, 1);
      return;
    end
    h = probe_lookup(pg);
    if (h >= 0) begin
      age_count++;
      age[h] = age_count;
      if (cmd == pcl_pkg::CMD_WRITE) dirty[h] = 1;
      push(1, 1, h, 0, 0, 0, 0, 1);
      return;
    end
    // victim: first invalid from slot 1 up, else oldest, ties to lower slot
    v = 0;
    for (int i = 1; i < NSLOT; i++) begin
      if (!valid[i]) begin
        v = i;
        break;
      end
      if (age[i] < age[v]) v = i;
    end
    if (valid[v]) begin
      if (dirty[v]) begin
        wv = 1; wp = tag[v];
      end
      probe_drop(tag[v], v);
    end
    valid[v] = 0; dirty[v] = 0; tag[v] = pg;
    if (ferr && cmd == pcl_pkg::CMD_READ) begin
      push(0, 0, 0, 1, 0, wv, wp, 1);
      return;
    end
    valid[v] = 1;
    age_count++;
    age[v] = age_count;
    probe_put(pg, v);
    if (cmd == pcl_pkg::CMD_WRITE) dirty[v] = 1;
    push(0, 1, v, 1, ferr, wv, wp, 1);
  endfunction

  function void check_result(cache_beat_t got);
    cache_beat_t want;
    beats_seen++;
    if (got.wb_valid) writebacks_seen++;
    if (got.hit) hits_seen++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("%0t: result beat with nothing expected", $realtime);
      return;
    end
    want = pending.pop_front();
    if (got != want) begin
      errors++;
      if (errors <= 10)
        $display("%0t: mismatch exp hit%0d ok%0d slot%0d fill%0d zf%0d wb%0d/%h last%0d",
                 $realtime, want.hit, want.ok, want.slot, want.fill_needed,
                 want.zero_filled, want.wb_valid, want.wb_page, want.last,
                 " got hit%0d ok%0d slot%0d fill%0d zf%0d wb%0d/%h last%0d",
                 got.hit, got.ok, got.slot, got.fill_needed, got.zero_filled,
                 got.wb_valid, got.wb_page, got.last);
    end
  endfunction
endclass

module testbench;
  localparam bit [1:0] CMD_BAD = 2'd3;
  localparam int LATENCY = 40;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  command = pcl_pkg::CMD_READ;
  logic [15:0] page = 0;
  logic        fill_error = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        hit, ok, fill_needed, zero_filled, writeback_valid, last;
  logic [3:0]  slot;
  logic [15:0] writeback_page;

  cache_scoreboard sb = new();
  int          send_idle_pct;
  int          recv_idle_pct;
  int          requests;
  bit [15:0]   hot_pages [24];

  page_cache_lru_controller dut (
    .clk, .rst, .in_valid, .in_ready, .command, .page, .fill_error,
    .out_valid, .out_ready, .hit, .ok, .slot, .fill_needed, .zero_filled,
    .writeback_valid, .writeback_page, .last
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // timeout guard
  initial begin
    #20_000_000;
    $display("FAIL page_cache_lru_controller");
    $finish;
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor both channels
  always @(posedge clk) begin
    cache_beat_t b;
    if (!rst && in_valid && in_ready) begin
      sb.note_request(command, page, fill_error);
      requests++;
    end
    if (!rst && out_valid && out_ready) begin
      b.hit = hit; b.ok = ok; b.slot = slot; b.fill_needed = fill_needed;
      b.zero_filled = zero_filled; b.wb_valid = writeback_valid;
      b.wb_page = writeback_page; b.last = last;
      sb.check_result(b);
    end
  end

  // one request beat; called at a rising edge, returns at the accepting edge
  task send_request(input bit [1:0] c, input bit [15:0] p, input bit f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    command <= c;
    page <= p;
    fill_error <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task drain_results();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task random_request();
    int r;
    bit [1:0] c;
    bit [15:0] p;
    r = $urandom_range(99);
    if (r < 42) c = pcl_pkg::CMD_READ;
    else if (r < 86) c = pcl_pkg::CMD_WRITE;
    else if (r < 97) c = pcl_pkg::CMD_SYNC;
    else c = CMD_BAD;
    p = ($urandom_range(99) < 65) ? hot_pages[$urandom_range(23)] : 16'($urandom);
    send_request(c, p, $urandom_range(99) < 12);
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    requests = 0;
    // half the hot set shares one probe bucket to build long clusters
    for (int i = 0; i < 24; i++)
      hot_pages[i] = (i < 12) ? ((16'($urandom) & 16'hFFC0) | 16'd9) : 16'($urandom);
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: page extremes, failed fills, hits that ignore fill errors
    send_request(pcl_pkg::CMD_READ, 16'h0000, 0);
    send_request(pcl_pkg::CMD_WRITE, 16'hFFFF, 0);
    send_request(pcl_pkg::CMD_READ, 16'h0000, 1);
    send_request(pcl_pkg::CMD_WRITE, 16'hFFFF, 1);
    send_request(pcl_pkg::CMD_READ, 16'h1234, 1);
    send_request(pcl_pkg::CMD_WRITE, 16'h5678, 1);
    send_request(pcl_pkg::CMD_SYNC, 16'hFFFF, 1);
    send_request(pcl_pkg::CMD_SYNC, 16'h0000, 0);
    send_request(CMD_BAD, 16'hAAAA, 1);
    // 17 colliding dirty writes force dirty evictions, then a full sync
    for (int k = 0; k < 17; k++)
      send_request(pcl_pkg::CMD_WRITE, 16'(k * 64 + 7), 0);
    send_request(pcl_pkg::CMD_READ, 16'd7, 0);
    send_request(pcl_pkg::CMD_SYNC, 16'h5555, 0);
    drain_results();

    // random phases with varied stall mix
    send_idle_pct = 31; recv_idle_pct = 73;
    repeat (150) random_request();
    drain_results();
    send_idle_pct = 73; recv_idle_pct = 31;
    repeat (150) random_request();
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (150) random_request();
    drain_results();

    $display("Covered %0d requests and %0d result beats (%0d hits, %0d writebacks).",
             requests, sb.beats_seen, sb.hits_seen, sb.writebacks_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS page_cache_lru_controller");
    end else begin
      $display("%0d errors, %0d results outstanding", sb.errors, sb.pending.size());
      $display("FAIL page_cache_lru_controller");
    end
    $finish;
  end
endmodule
`default_nettype wire
